/* hw/rtl/keyword_substitution_cipher_macros.svh */
// Assertion macros for the cipher datapath.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ksc_pkg.sv */
// Shared constants, types and helpers for the keyword substitution cipher.
package ksc_pkg;

    localparam int Letters = 26;
    localparam int LetterW = 5;
    localparam int CmdW    = 3;
    localparam int CharW   = 8;

    localparam logic [CmdW-1:0] CmdStart   = 3'd0;
    localparam logic [CmdW-1:0] CmdKeyChar = 3'd1;
    localparam logic [CmdW-1:0] CmdFinish  = 3'd2;
    localparam logic [CmdW-1:0] CmdEncrypt = 3'd3;
    localparam logic [CmdW-1:0] CmdDecrypt = 3'd4;

    localparam logic [CharW-1:0] CharLowerA = 8'h61;
    localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
    localparam logic [CharW-1:0] CharUpperA = 8'h41;
    localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
    localparam logic [CharW-1:0] CharSpace  = 8'h20;

    localparam logic [LetterW-1:0] LastLetter = 5'(Letters - 1);
    localparam logic [LetterW-1:0] KeyFull    = 5'(Letters);

    typedef struct packed {
        logic               is_letter;
        logic [LetterW-1:0] idx;
    } letter_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_key;
        logic append_char;
        logic walk_init;
        logic walk_step;
        logic emit_enc;
        logic emit_space;
        logic emit_pend;
    } ksc_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
        logic walk_done;
    } ksc_stat_t;

    function automatic letter_t letter_of(input logic [CharW-1:0] c);
        letter_t r;
        r.is_letter = 1'b0;
        r.idx       = '0;
        if (c >= CharLowerA && c <= CharLowerZ)
        begin
            r.is_letter = 1'b1;
            r.idx       = LetterW'(c - CharLowerA);
        end
        else if (c >= CharUpperA && c <= CharUpperZ)
        begin
            r.is_letter = 1'b1;
            r.idx       = LetterW'(c - CharUpperA);
        end
        return r;
    endfunction

    function automatic logic [CharW-1:0] lower_char(input logic [LetterW-1:0] v);
        return CharLowerA + {3'b000, v};
    endfunction

endpackage

/* hw/rtl/keyword_substitution_cipher.sv */
// Keyword substitution cipher: one transfer in, zero to two transfers out.
// Results are registered; the encrypt result and the first decrypt result appear
// in the cycle after the input transfer. Decrypt sends two results through the
// single output register; finish runs the walk counter, one letter per cycle from
// z down to a. The input stalls while either runs and whenever the output is held.
// Reset clears the key and output valid and sets both tables to identity at once.
module keyword_substitution_cipher
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ksc_pkg::CmdW-1:0]    command,
    input  logic [ksc_pkg::CharW-1:0]   data_char,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ksc_pkg::CharW-1:0]   out_char,
    output logic                        last
);

    ksc_pkg::ksc_cmd_t  cmd;
    ksc_pkg::ksc_stat_t stat;

    ksc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    ksc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_char (data_char),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

/* hw/rtl/ksc_ctrl.sv */
// Controller: input handshake, command decode and sequencing of walk and decrypt.
module ksc_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ksc_pkg::CmdW-1:0]  command,
    input  ksc_pkg::ksc_stat_t        stat,
    output ksc_pkg::ksc_cmd_t         cmd
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StWalk = 2'd1;
    localparam logic [1:0] StDec2 = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != StIdle) || !stat.out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    unique case (command)
                        ksc_pkg::CmdStart:   cmd.clear_key   = 1'b1;
                        ksc_pkg::CmdKeyChar: cmd.append_char = 1'b1;
                        ksc_pkg::CmdFinish:
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = StWalk;
                        end
                        ksc_pkg::CmdEncrypt: cmd.emit_enc = 1'b1;
                        ksc_pkg::CmdDecrypt:
                        begin
                            cmd.emit_space = 1'b1;
                            state_next     = StDec2;
                        end
                        default: ;
                    endcase
                end
            end
            StWalk:
            begin
                // one letter per cycle, z down to a
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                    state_next = StIdle;
            end
            StDec2:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pend = 1'b1;
                    state_next    = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= StIdle;
        else
            state_reg <= state_next;
    end

endmodule

/* hw/rtl/ksc_datapath.sv */
// Datapath: key state, cipher tables, walk counter and output register.
`include "keyword_substitution_cipher_macros.svh"

module ksc_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ksc_pkg::CharW-1:0]   data_char,
    input  ksc_pkg::ksc_cmd_t           cmd,
    output ksc_pkg::ksc_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ksc_pkg::CharW-1:0]   out_char,
    output logic                        last
);

    logic [ksc_pkg::Letters-1:0] mask_reg;
    logic [ksc_pkg::Letters-1:0] mask_next;
    logic [ksc_pkg::LetterW-1:0] key_len_reg;
    logic [ksc_pkg::LetterW-1:0] key_len_next;
    logic [ksc_pkg::LetterW-1:0] walk_idx_reg;
    logic [ksc_pkg::LetterW-1:0] walk_idx_next;
    logic [ksc_pkg::LetterW-1:0] fwd_reg [ksc_pkg::Letters];
    logic [ksc_pkg::LetterW-1:0] inv_reg [ksc_pkg::Letters];

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ksc_pkg::CharW-1:0]   out_char_reg;
    logic [ksc_pkg::CharW-1:0]   out_char_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic [ksc_pkg::CharW-1:0]   pend_reg;
    logic [ksc_pkg::CharW-1:0]   pend_next;

    ksc_pkg::letter_t            in_letter;
    logic [ksc_pkg::LetterW-1:0] app_idx;
    logic                        app_req;
    logic                        do_append;
    logic [ksc_pkg::CharW-1:0]   enc_char;
    logic [ksc_pkg::CharW-1:0]   dec_char;

    assign in_letter = ksc_pkg::letter_of(data_char);
    assign app_idx   = cmd.walk_step ? walk_idx_reg : in_letter.idx;
    assign app_req   = cmd.walk_step || (cmd.append_char && in_letter.is_letter);
    assign do_append = app_req && (key_len_reg < ksc_pkg::KeyFull) && !mask_reg[app_idx];

    assign enc_char = in_letter.is_letter ? ksc_pkg::lower_char(fwd_reg[in_letter.idx])
                                          : data_char;
    assign dec_char = in_letter.is_letter ? ksc_pkg::lower_char(inv_reg[in_letter.idx])
                                          : data_char;

    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.walk_done = (walk_idx_reg == '0);

    always_comb
    begin
        mask_next     = mask_reg;
        key_len_next  = key_len_reg;
        walk_idx_next = walk_idx_reg;
        pend_next     = pend_reg;
        if (cmd.clear_key)
        begin
            mask_next    = '0;
            key_len_next = '0;
        end
        else if (do_append)
        begin
            mask_next[app_idx] = 1'b1;
            key_len_next       = key_len_reg + 5'd1;
        end
        if (cmd.walk_init)
            walk_idx_next = ksc_pkg::LastLetter;
        else if (cmd.walk_step && !stat.walk_done)
            walk_idx_next = walk_idx_reg - 5'd1;
        if (cmd.emit_space)
            pend_next = dec_char;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_enc)
        begin
            out_valid_next = 1'b1;
            out_char_next  = enc_char;
            out_last_next  = 1'b1;
        end
        else if (cmd.emit_space)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ksc_pkg::CharSpace;
            out_last_next  = 1'b0;
        end
        else if (cmd.emit_pend)
        begin
            out_valid_next = 1'b1;
            out_char_next  = pend_reg;
            out_last_next  = 1'b1;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            key_len_reg   <= '0;
            walk_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            key_len_reg   <= key_len_next;
            walk_idx_reg  <= walk_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        pend_reg     <= pend_next;
    end

    // Tables come out of reset as the identity mapping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ksc_pkg::Letters; i++)
            begin
                fwd_reg[i] <= ksc_pkg::LetterW'(i);
                inv_reg[i] <= ksc_pkg::LetterW'(i);
            end
        end
        else if (do_append && !cmd.clear_key)
        begin
            fwd_reg[key_len_reg] <= app_idx;
            inv_reg[app_idx]     <= key_len_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = out_last_reg;

    `KSC_ASSERT_SAME(a_len_matches_mask, 1'b1,
        $countones(mask_reg) == 32'(key_len_reg), "key length disagrees with used mask")
    `KSC_ASSERT_SAME(a_emit_needs_room, cmd.emit_enc || cmd.emit_space || cmd.emit_pend,
        stat.out_free, "result loaded while output register is still held")
    `KSC_ASSERT_NEXT(a_walk_counts_down, cmd.walk_step && !stat.walk_done,
        walk_idx_reg == $past(walk_idx_reg) - 5'd1, "walk counter did not step")

endmodule

/* tb/tb_top.sv */
// Testbench for the keyword substitution cipher: directed table, then random key and message streams.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ksc_pkg::*;

    localparam logic [CmdW-1:0] CmdSpare5 = 3'd5;
    localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

    localparam int RandomItems  = 400;
    localparam int CalmTail     = 60;
    localparam int SettleCycles = 40;

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             fin;
    } cipher_out_t;

    // typed = 1: the result is written in the row; n_out results, r0 then r1
    typedef struct packed {
        logic [CmdW-1:0]  cmd;
        logic [CharW-1:0] ch;
        logic             typed;
        logic [1:0]       n_out;
        logic [CharW-1:0] r0;
        logic [CharW-1:0] r1;
    } step_row_t;

    localparam step_row_t StepTab [27] = '{
        '{CmdEncrypt, "a",   1'b1, 2'd1, "a",   8'h00},
        '{CmdEncrypt, "Z",   1'b1, 2'd1, "z",   8'h00},
        '{CmdEncrypt, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00},
        '{CmdEncrypt, 8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{CmdDecrypt, "M",   1'b1, 2'd2, " ",   "m"},
        '{CmdDecrypt, 8'h80, 1'b1, 2'd2, " ",   8'h80},
        '{CmdSpare5,  "a",   1'b1, 2'd0, 8'h00, 8'h00},
        '{CmdSpare7,  8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
        '{CmdFinish,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdEncrypt, "a",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdDecrypt, "A",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdStart,   8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "K",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "e",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "Y",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "k",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "1",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, 8'hC1, 1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdEncrypt, "a",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdDecrypt, "b",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdFinish,  "x",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdEncrypt, "z",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdDecrypt, "@",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdEncrypt, "[",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdEncrypt, "{",   1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdFinish,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
        '{CmdKeyChar, "q",   1'b0, 2'd0, 8'h00, 8'h00}
    };

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [CmdW-1:0]  command   = '0;
    logic [CharW-1:0] data_char = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [CharW-1:0] out_char;
    logic             last;

    keyword_substitution_cipher dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .data_char (data_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Shadow key state
    logic [Letters-1:0] used_letters;
    int                 key_len;
    logic [LetterW-1:0] fwd_tab [Letters];
    logic [LetterW-1:0] inv_tab [Letters];

    cipher_out_t cipher_out_q [$];
    int          errors     = 0;
    int          sent_items = 0;
    int          stall_left = 0;
    bit          idle_on    = 1'b0;

    function automatic int letter_pos(input logic [CharW-1:0] c);
        if (c >= CharLowerA && c <= CharLowerZ)
            return int'(c - CharLowerA);
        if (c >= CharUpperA && c <= CharUpperZ)
            return int'(c - CharUpperA);
        return -1;
    endfunction

    task automatic key_add(input int idx);
        if (key_len < Letters && !used_letters[idx])
        begin
            fwd_tab[key_len] = LetterW'(idx);
            inv_tab[idx]     = LetterW'(key_len);
            used_letters[idx] = 1'b1;
            key_len++;
        end
    endtask

    // Advance the shadow key; queue the cipher output when keep is set
    task automatic predict_cipher(input logic [CmdW-1:0] cmd, input logic [CharW-1:0] ch,
                                  input bit keep);
        int          pos;
        cipher_out_t r;
        pos = letter_pos(ch);
        case (cmd)
            CmdStart:
            begin
                used_letters = '0;
                key_len      = 0;
            end
            CmdKeyChar:
                if (pos >= 0)
                    key_add(pos);
            CmdFinish:
                for (int k = Letters - 1; k >= 0; k--)
                    key_add(k);
            CmdEncrypt:
                if (keep)
                begin
                    r.ch  = (pos >= 0) ? CharLowerA + fwd_tab[pos] : ch;
                    r.fin = 1'b1;
                    cipher_out_q.push_back(r);
                end
            CmdDecrypt:
                if (keep)
                begin
                    r.ch  = CharSpace;
                    r.fin = 1'b0;
                    cipher_out_q.push_back(r);
                    r.ch  = (pos >= 0) ? CharLowerA + inv_tab[pos] : ch;
                    r.fin = 1'b1;
                    cipher_out_q.push_back(r);
                end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [CharW-1:0] got,
                                   input logic [CharW-1:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic send_item(input logic [CmdW-1:0] c, input logic [CharW-1:0] ch,
                             input bit keep = 1'b1);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= c;
        data_char <= ch;
        do
            @(posedge clk);
        while (in_stall);
        predict_cipher(c, ch, keep);
        if (c <= CmdDecrypt)
            sent_items++;
    endtask

    function automatic logic [CharW-1:0] pick_char();
        case ($urandom_range(0, 3))
            0:       return CharLowerA + CharW'($urandom_range(0, 25));
            1:       return CharUpperA + CharW'($urandom_range(0, 25));
            default: return CharW'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CharW-1:0] pick_key_char();
        if ($urandom_range(0, 4) == 0)
            return CharW'($urandom_range(0, 255));
        return ($urandom_range(0, 1) ? CharLowerA : CharUpperA) + CharW'($urandom_range(0, 25));
    endfunction

    function automatic logic [CmdW-1:0] pick_msg_cmd();
        return $urandom_range(0, 1) ? CmdEncrypt : CmdDecrypt;
    endfunction

    task automatic send_message(input int n);
        repeat (n) send_item(pick_msg_cmd(), pick_char());
    endtask

    // Compare each output transfer; drive receiver stall bursts
    always @(posedge clk)
    begin : out_check
        cipher_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_out_q.size() == 0)
                    report_mismatch("unexpected output char", out_char, 8'h00);
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch("out_char", out_char, want.ch);
                    if (last !== want.fin)
                        report_mismatch("last", {7'd0, last}, {7'd0, want.fin});
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        int          n;
        int          perm [Letters];
        int          j;
        int          tmp;
        bit          paused;
        cipher_out_t r;

        used_letters = '0;
        key_len      = 0;
        for (int i = 0; i < Letters; i++)
        begin
            fwd_tab[i] = LetterW'(i);
            inv_tab[i] = LetterW'(i);
        end
        paused = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        foreach (StepTab[i])
        begin
            send_item(StepTab[i].cmd, StepTab[i].ch, !StepTab[i].typed);
            if (StepTab[i].typed && StepTab[i].n_out != 2'd0)
            begin
                r.ch  = StepTab[i].r0;
                r.fin = (StepTab[i].n_out == 2'd1);
                cipher_out_q.push_back(r);
                if (StepTab[i].n_out == 2'd2)
                begin
                    r.ch  = StepTab[i].r1;
                    r.fin = 1'b1;
                    cipher_out_q.push_back(r);
                end
            end
        end

        sent_items = 0;
        while (sent_items < RandomItems)
        begin
            idle_on = (sent_items < RandomItems - CalmTail) && ($urandom_range(0, 3) != 0);
            // Hold the sender once until the output side has drained
            if (!paused && sent_items >= RandomItems / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (cipher_out_q.size() != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_item(CmdStart, pick_char());
                    n = $urandom_range(0, 30);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_item(pick_msg_cmd(), pick_char());
                        else
                            send_item(CmdKeyChar, pick_key_char());
                    end
                    send_item(CmdFinish, pick_char());
                    send_message($urandom_range(1, 12));
                end
                6:
                begin
                    // full keyword, then check that extra key input is ignored
                    for (int i = 0; i < Letters; i++)
                        perm[i] = i;
                    for (int i = Letters - 1; i > 0; i--)
                    begin
                        j       = $urandom_range(0, i);
                        tmp     = perm[i];
                        perm[i] = perm[j];
                        perm[j] = tmp;
                    end
                    send_item(CmdStart, pick_char());
                    for (int i = 0; i < Letters; i++)
                        send_item(CmdKeyChar, ($urandom_range(0, 1) ? CharLowerA : CharUpperA)
                                  + CharW'(perm[i]));
                    send_item(CmdKeyChar, pick_key_char());
                    send_item(CmdFinish, pick_char());
                    send_message($urandom_range(1, 12));
                end
                7:
                    repeat ($urandom_range(1, 8))
                        send_item(CmdW'($urandom_range(0, 7)), CharW'($urandom_range(0, 255)));
                8:
                begin
                    repeat ($urandom_range(1, 4)) send_item(CmdKeyChar, pick_key_char());
                    send_item(CmdFinish, pick_char());
                    send_message($urandom_range(1, 6));
                end
                default:
                    send_message($urandom_range(1, 12));
            endcase
        end
        in_valid <= 1'b0;
        idle_on = 1'b0;

        while (cipher_out_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout at %0t", $time);
        $display("FAILURE");
        $finish;
    end

endmodule
